/* hw/rtl/sphere_map_texel_index_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sphere map texel index unit
// Concurrent checks clocked by i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPHERE_MAP_TEXEL_INDEX_UNIT_MACROS_SVH
`define SPHERE_MAP_TEXEL_INDEX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SMTI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smti check failed");
`define SMTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smti check failed");
`else
`define SMTI_ASSERT_IMP(lbl, ante, cons)
`define SMTI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/smti_pkg.sv */
// ----------------------------------------------------------------------------
// smti_pkg
// Constants, types and helper functions of the sphere map texel index unit.
// ----------------------------------------------------------------------------
package smti_pkg;

    localparam int DIR_BITS_DEF  = 24;
    localparam int MAX_DIM_DEF   = 4096;
    localparam int DIM_W         = 13;
    localparam int IDX_W         = 12;
    localparam int ADDR_W        = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int NORM_W        = 32;
    localparam int CORD_W        = 37;
    localparam int ACC_W         = 32;
    localparam int FRAC_W        = 24;
    localparam int CORDIC_STAGES = 28;
    localparam int SHIFT_W       = 5;
    localparam int NORM_TOP_BIT  = 30;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195364;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_index;

    // atan(2^-i) as a fraction of a turn, scaled by 2^32.
    function automatic logic [ACC_W-1:0] atan_turn(input int idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
            27: v = 32'h00000005;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Image sizes of zero read as one, sizes above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/sphere_map_texel_index_unit.sv */
// ----------------------------------------------------------------------------
// sphere_map_texel_index_unit
// Maps a 3D direction to a texel of an equirectangular environment image.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   in        sink       i_in_valid/o_in_stall  i_dir_x, i_dir_y, i_dir_z
//   out       source     o_out_valid/i_out_stall o_texel_column, o_texel_row,
//                                               o_texel_address, o_zero_direction
//   cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat enters per cycle while no stalled beat waits at the output; the
// pipeline is made of the two 28-stage CORDIC vectoring pipelines, one stage
// per iteration, plus normalization, gain and index stages.
// Reset is synchronous and active low; it clears the valid bits and sets
// both image sizes to one. The configuration port is always ready.
// A stall on a valid output beat freezes the whole pipeline in place; the
// input then stalls in the same cycle, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "sphere_map_texel_index_unit_macros.svh"

module sphere_map_texel_index_unit
    import smti_pkg::*;
#(
    parameter int MAX_DIM  = MAX_DIM_DEF,
    parameter int DIR_BITS = DIR_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [DIR_BITS-1:0]  i_dir_x,
    input  logic signed [DIR_BITS-1:0]  i_dir_y,
    input  logic signed [DIR_BITS-1:0]  i_dir_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [IDX_W-1:0]            o_texel_column,
    output logic [IDX_W-1:0]            o_texel_row,
    output logic [ADDR_W-1:0]           o_texel_address,
    output logic                        o_zero_direction,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DIM_W-1:0]            i_cfg_data
);

    // Stage count: A, B, C, D, first CORDIC, E, second CORDIC, F, G, H.
    localparam int LAT = 4 + CORDIC_STAGES + 1 + CORDIC_STAGES + 3;

    logic en;
    logic [LAT-1:0] r_vld;
    logic [DIM_W-1:0] r_w, r_h;

    // Whole pipeline advances unless the output holds a beat that is stalled.
    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Image sizes are stored already clamped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= DIM_W'(1);
            r_h <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_w <= clamp_dim(i_cfg_data, MAX_DIM);
                CFG_IMAGE_HEIGHT: r_h <= clamp_dim(i_cfg_data, MAX_DIM);
                default: ;
            endcase
        end
    end

    // Stage A: capture the direction and the OR of the component magnitudes.
    logic signed [DIR_BITS-1:0] r_a_x, r_a_y, r_a_z;
    logic [DIR_BITS-1:0] r_a_m;
    logic [DIR_BITS-1:0] mag_x, mag_y, mag_z;

    assign mag_x = i_dir_x[DIR_BITS-1] ? (~i_dir_x + 1'b1) : i_dir_x;
    assign mag_y = i_dir_y[DIR_BITS-1] ? (~i_dir_y + 1'b1) : i_dir_y;
    assign mag_z = i_dir_z[DIR_BITS-1] ? (~i_dir_z + 1'b1) : i_dir_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x <= i_dir_x;
            r_a_y <= i_dir_y;
            r_a_z <= i_dir_z;
            r_a_m <= mag_x | mag_y | mag_z;
        end
    end

    // Stage B: find the normalizing shift that lifts the top bit to bit 30.
    logic signed [DIR_BITS-1:0] r_b_x, r_b_y, r_b_z;
    logic [SHIFT_W-1:0] r_b_s, msb, n_b_s;
    logic r_b_zero;

    always_comb begin
        msb = '0;
        for (int k = 0; k < DIR_BITS; k++) begin
            if (r_a_m[k]) begin
                msb = SHIFT_W'(k);
            end
        end
        n_b_s = (msb >= SHIFT_W'(NORM_TOP_BIT)) ? '0 : SHIFT_W'(NORM_TOP_BIT) - msb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_x    <= r_a_x;
            r_b_y    <= r_a_y;
            r_b_z    <= r_a_z;
            r_b_s    <= n_b_s;
            r_b_zero <= (r_a_m == '0);
        end
    end

    // Stage C: shift, and fold the left half plane onto the right one.
    logic signed [NORM_W-1:0] xn, yn, zn;
    logic signed [CORD_W-1:0] r_c_a, r_c_b;
    logic signed [NORM_W-1:0] r_c_y;
    logic r_c_hp, r_c_axis, r_c_zero;

    assign xn = NORM_W'(r_b_x) <<< r_b_s;
    assign yn = NORM_W'(r_b_y) <<< r_b_s;
    assign zn = NORM_W'(r_b_z) <<< r_b_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (xn < 0) begin
                r_c_a <= -CORD_W'(xn);
                r_c_b <= -CORD_W'(zn);
            end else begin
                r_c_a <= CORD_W'(xn);
                r_c_b <= CORD_W'(zn);
            end
            r_c_hp   <= (xn < 0);
            r_c_axis <= (zn == 0);
            r_c_y    <= yn;
            r_c_zero <= r_b_zero;
        end
    end

    // Stage D: gain products for the on-axis length and for the polar y.
    localparam int PROD_W = CORD_W + 32;
    logic signed [PROD_W-1:0] ag_p, yg_p;

    assign ag_p = PROD_W'(r_c_a) * PROD_W'(GAIN_Q30);
    assign yg_p = PROD_W'(r_c_y) * PROD_W'(GAIN_Q30);

    logic signed [CORD_W-1:0] r_c1_a   [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] r_c1_b   [0:CORDIC_STAGES];
    logic        [ACC_W-1:0]  r_c1_acc [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] r_c1_ag  [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] r_c1_yg  [0:CORDIC_STAGES];
    logic                     r_c1_hp  [0:CORDIC_STAGES];
    logic                     r_c1_ax  [0:CORDIC_STAGES];
    logic                     r_c1_zr  [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1_a[0]   <= r_c_a;
            r_c1_b[0]   <= r_c_b;
            r_c1_acc[0] <= {r_c_hp, {(ACC_W-1){1'b0}}};
            r_c1_ag[0]  <= CORD_W'(ag_p >>> 30);
            r_c1_yg[0]  <= CORD_W'(yg_p >>> 30);
            r_c1_hp[0]  <= r_c_hp;
            r_c1_ax[0]  <= r_c_axis;
            r_c1_zr[0]  <= r_c_zero;
        end
    end

    // Azimuth CORDIC: one vectoring iteration per stage.
    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_c1
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_c1_b[gi] >= 0) begin
                    r_c1_a[gi+1]   <= r_c1_a[gi] + (r_c1_b[gi] >>> gi);
                    r_c1_b[gi+1]   <= r_c1_b[gi] - (r_c1_a[gi] >>> gi);
                    r_c1_acc[gi+1] <= r_c1_acc[gi] + atan_turn(gi);
                end else begin
                    r_c1_a[gi+1]   <= r_c1_a[gi] - (r_c1_b[gi] >>> gi);
                    r_c1_b[gi+1]   <= r_c1_b[gi] + (r_c1_a[gi] >>> gi);
                    r_c1_acc[gi+1] <= r_c1_acc[gi] - atan_turn(gi);
                end
                r_c1_ag[gi+1] <= r_c1_ag[gi];
                r_c1_yg[gi+1] <= r_c1_yg[gi];
                r_c1_hp[gi+1] <= r_c1_hp[gi];
                r_c1_ax[gi+1] <= r_c1_ax[gi];
                r_c1_zr[gi+1] <= r_c1_zr[gi];
            end
        end
    end

    // Stage E: azimuth fraction, then set up the polar CORDIC on (y, r).
    logic signed [CORD_W-1:0] rad, yg_e;
    logic [ACC_W-1:0] acc1;
    logic [ACC_W:0] az_sum;

    assign rad    = r_c1_ax[CORDIC_STAGES] ? r_c1_ag[CORDIC_STAGES] : r_c1_a[CORDIC_STAGES];
    assign acc1   = r_c1_ax[CORDIC_STAGES] ? {r_c1_hp[CORDIC_STAGES], {(ACC_W-1){1'b0}}}
                                           : r_c1_acc[CORDIC_STAGES];
    assign az_sum = {1'b0, acc1} + (ACC_W+1)'(128);
    assign yg_e   = r_c1_yg[CORDIC_STAGES];

    logic signed [CORD_W-1:0] r_c2_a   [0:CORDIC_STAGES];
    logic signed [CORD_W-1:0] r_c2_b   [0:CORDIC_STAGES];
    logic        [ACC_W-1:0]  r_c2_acc [0:CORDIC_STAGES];
    logic        [FRAC_W-1:0] r_c2_az  [0:CORDIC_STAGES];
    logic                     r_c2_hp  [0:CORDIC_STAGES];
    logic                     r_c2_ax  [0:CORDIC_STAGES];
    logic                     r_c2_zr  [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (yg_e < 0) begin
                r_c2_a[0] <= -yg_e;
                r_c2_b[0] <= -rad;
            end else begin
                r_c2_a[0] <= yg_e;
                r_c2_b[0] <= rad;
            end
            r_c2_acc[0] <= {(yg_e < 0), {(ACC_W-1){1'b0}}};
            r_c2_hp[0]  <= (yg_e < 0);
            r_c2_ax[0]  <= (rad == 0);
            r_c2_az[0]  <= az_sum[ACC_W-1:8];
            r_c2_zr[0]  <= r_c1_zr[CORDIC_STAGES];
        end
    end

    // Polar CORDIC.
    for (genvar gj = 0; gj < CORDIC_STAGES; gj++) begin : g_c2
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_c2_b[gj] >= 0) begin
                    r_c2_a[gj+1]   <= r_c2_a[gj] + (r_c2_b[gj] >>> gj);
                    r_c2_b[gj+1]   <= r_c2_b[gj] - (r_c2_a[gj] >>> gj);
                    r_c2_acc[gj+1] <= r_c2_acc[gj] + atan_turn(gj);
                end else begin
                    r_c2_a[gj+1]   <= r_c2_a[gj] - (r_c2_b[gj] >>> gj);
                    r_c2_b[gj+1]   <= r_c2_b[gj] + (r_c2_a[gj] >>> gj);
                    r_c2_acc[gj+1] <= r_c2_acc[gj] - atan_turn(gj);
                end
                r_c2_az[gj+1] <= r_c2_az[gj];
                r_c2_hp[gj+1] <= r_c2_hp[gj];
                r_c2_ax[gj+1] <= r_c2_ax[gj];
                r_c2_zr[gj+1] <= r_c2_zr[gj];
            end
        end
    end

    // Stage F: fold the polar angle into [0, half turn] and round it.
    logic [ACC_W-1:0] acc2, acc2c;
    logic [ACC_W:0] pol_sum;
    logic [FRAC_W:0] pol_f;
    logic [FRAC_W-1:0] r_f_az;
    logic [FRAC_W:0] r_f_pol;
    logic r_f_zero;

    always_comb begin
        acc2 = r_c2_ax[CORDIC_STAGES] ? {r_c2_hp[CORDIC_STAGES], {(ACC_W-1){1'b0}}}
                                      : r_c2_acc[CORDIC_STAGES];
        if (acc2 > 32'hC000_0000) begin
            acc2c = '0;
        end else if (acc2 > 32'h8000_0000) begin
            acc2c = 32'h8000_0000;
        end else begin
            acc2c = acc2;
        end
        pol_sum = {1'b0, acc2c} + (ACC_W+1)'(64);
        // The sum never exceeds a half turn plus rounding, so bit 32 is clear.
        pol_f = (pol_sum[ACC_W:7] > 26'h100_0000) ? 25'h100_0000 : pol_sum[31:7];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_az   <= r_c2_zr[CORDIC_STAGES] ? '0 : r_c2_az[CORDIC_STAGES];
            r_f_pol  <= r_c2_zr[CORDIC_STAGES] ? '0 : pol_f;
            r_f_zero <= r_c2_zr[CORDIC_STAGES];
        end
    end

    // Stage G: scale the fractions by the image size.
    logic [FRAC_W+DIM_W-1:0] col_p;
    logic [FRAC_W+DIM_W:0] row_p;
    logic [DIM_W:0] row_raw;
    logic [DIM_W-1:0] r_g_col, r_g_row;
    logic r_g_zero;

    assign col_p   = r_f_az * r_w;
    assign row_p   = r_f_pol * r_h;
    assign row_raw = row_p[FRAC_W+DIM_W:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_col  <= col_p[FRAC_W+DIM_W-1:FRAC_W];
            // The south pole lands on row H, which wraps to row zero.
            r_g_row  <= (row_raw == {1'b0, r_h}) ? '0 : row_raw[DIM_W-1:0];
            r_g_zero <= r_f_zero;
        end
    end

    // Stage H: linear address and output register.
    logic [2*DIM_W:0] addr;
    logic [IDX_W-1:0] r_h_col, r_h_row;
    logic [ADDR_W-1:0] r_h_addr;
    logic r_h_zero;

    assign addr = (2*DIM_W+1)'(r_g_row * r_w) + (2*DIM_W+1)'(r_g_col);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_col  <= r_g_col[IDX_W-1:0];
            r_h_row  <= r_g_row[IDX_W-1:0];
            r_h_addr <= addr[ADDR_W-1:0];
            r_h_zero <= r_g_zero;
        end
    end

    assign o_texel_column   = r_h_col;
    assign o_texel_row      = r_h_row;
    assign o_texel_address  = r_h_addr;
    assign o_zero_direction = r_h_zero;

    // All three indices at zero, as a zero direction requires.
    logic idx_is_zero;
    assign idx_is_zero = (o_texel_address == '0) && (o_texel_column == '0)
                         && (o_texel_row == '0);

    `SMTI_ASSERT_IMP(a_stall_back, o_out_valid && i_out_stall, o_in_stall)
    `SMTI_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `SMTI_ASSERT_IMP(a_zero_idx, o_out_valid && o_zero_direction, idx_is_zero)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the sphere map texel index unit
// Drives directions and image sizes into the unit and predicts every texel
// result with a CORDIC model of its own. Results are checked in order, field
// by field, with and without random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import smti_pkg::*;

    localparam int LATENCY = 64;

    // The texel result of one direction.
    typedef struct packed {
        logic [IDX_W-1:0]  column;
        logic [IDX_W-1:0]  row;
        logic [ADDR_W-1:0] address;
        logic              zero_dir;
    } t_texel;

    // Notes expected texels per accepted direction and checks results in order.
    class texel_scoreboard;
        t_texel pending[$];
        int     mismatches;
        int     checked;

        function void note_direction(t_texel t);
            pending.push_back(t);
        endfunction

        function void check_result(t_texel got);
            t_texel want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with no direction pending: col %0d row %0d",
                             got.column, got.row);
                end
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("texel mismatch: want col %0d row %0d addr %0d zero %0b",
                             want.column, want.row, want.address, want.zero_dir);
                    $display("                 got col %0d row %0d addr %0d zero %0b",
                             got.column, got.row, got.address, got.zero_dir);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic signed [23:0]  dir_x = '0;
    logic signed [23:0]  dir_y = '0;
    logic signed [23:0]  dir_z = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [IDX_W-1:0]    texel_column;
    logic [IDX_W-1:0]    texel_row;
    logic [ADDR_W-1:0]   texel_address;
    logic                zero_direction;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]    cfg_data = '0;

    texel_scoreboard board;

    // The unit's configuration as the predictor sees it.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Idling rates in percent, changed per phase.
    int sender_idle;
    int receiver_stall;

    always #5 clk = ~clk;

    sphere_map_texel_index_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_dir_x          (dir_x),
        .i_dir_y          (dir_y),
        .i_dir_z          (dir_z),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_texel_column   (texel_column),
        .o_texel_row      (texel_row),
        .o_texel_address  (texel_address),
        .o_zero_direction (zero_direction),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // Arithmetic shift right that rounds toward minus infinity.
    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint effective_dim(logic [DIM_W-1:0] r);
        if (r == 0) return 1;
        if (r > 4096) return 4096;
        return r;
    endfunction

    // Vectoring CORDIC: angle of (a, b) in turns scaled by 2^32, and the
    // rotated length, which carries the CORDIC gain.
    function automatic logic [31:0] vector_turns(longint a, longint b,
                                                 output longint length);
        logic [31:0] acc;
        longint      da;
        longint      db;
        acc = '0;
        if (a < 0) begin
            a = -a;
            b = -b;
            acc = 32'h8000_0000;
        end
        if (b == 0) begin
            length = floor_shift(a * 64'sd1768195364, 30);
            return acc;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            da = floor_shift(b, i);
            db = floor_shift(a, i);
            if (b >= 0) begin
                a += da;
                b -= db;
                acc += atan_turn(i);
            end else begin
                a -= da;
                b += db;
                acc -= atan_turn(i);
            end
        end
        length = a;
        return acc;
    endfunction

    function automatic t_texel texel_of(logic signed [23:0] vx,
                                        logic signed [23:0] vy,
                                        logic signed [23:0] vz);
        t_texel      t;
        longint      x;
        longint      y;
        longint      z;
        longint      w;
        longint      h;
        longint      ored;
        longint      radius;
        longint      unused_len;
        longint      azimuth;
        longint      polar;
        longint      col;
        longint      row;
        logic [31:0] acc;
        int          s;
        x = vx;
        y = vy;
        z = vz;
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        ored = (x < 0 ? -x : x) | (y < 0 ? -y : y) | (z < 0 ? -z : z);
        t = '0;
        if (ored == 0) begin
            t.zero_dir = 1'b1;
            return t;
        end
        // Normalize so that the largest magnitude reaches bit 30.
        s = 0;
        while (s < 31 && (ored << s) < 64'd1073741824) s++;
        x = x << s;
        y = y << s;
        z = z << s;
        acc = vector_turns(x, z, radius);
        azimuth = ((longint'(acc) + 128) >> 8) & 24'hFFFFFF;
        acc = vector_turns(floor_shift(y * 64'sd1768195364, 30), radius, unused_len);
        // Angles past three quarters of a turn are tiny negative ones near the
        // pole; those between a half and three quarters saturate at the south pole.
        if (acc > 32'hC000_0000) acc = '0;
        else if (acc > 32'h8000_0000) acc = 32'h8000_0000;
        polar = (longint'(acc) + 64) >> 7;
        if (polar > 64'h100_0000) polar = 64'h100_0000;
        col = ((azimuth * w) >> 24) % w;
        row = ((polar * h) >> 24) % h;
        t.column = col[IDX_W-1:0];
        t.row = row[IDX_W-1:0];
        t.address = ADDR_W'(row * w + col);
        return t;
    endfunction

    // Writes one size register while the unit holds no beat.
    task automatic write_size(t_cfg_index idx, logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        @(posedge clk);
    endtask

    // Sends one direction beat, with random idle cycles before it. The beat is
    // noted as soon as the edge that accepts it has passed.
    task automatic send_direction(logic signed [23:0] vx, logic signed [23:0] vy,
                                  logic signed [23:0] vz);
        while ($urandom_range(99) < sender_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dir_x <= vx;
        dir_y <= vy;
        dir_z <= vz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_direction(texel_of(vx, vy, vz));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // Random component: full range, small values, zero, or near the extremes.
    function automatic logic signed [23:0] random_component();
        case ($urandom_range(5))
            0: return 24'($signed($urandom_range(8)) - 4);
            1: return 24'($signed($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? 24'(24'sh7FFFFF - $urandom_range(3))
                                        : 24'(24'sh800000 + $urandom_range(3));
            3: return 24'sd0;
            default: return 24'($urandom);
        endcase
    endfunction

    // Receiver: stalls at random and checks every accepted result.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                board.check_result({texel_column, texel_row, texel_address,
                                    zero_direction});
            end
            out_stall <= ($urandom_range(99) < receiver_stall);
        end
    end

    initial begin
        #50_000_000;
        $display("** sphere_map_texel_index_unit: FAILED **");
        $finish;
    end

    localparam logic [DIM_W-1:0] SIZE_SET[8] = '{13'd1, 13'd4096, 13'd0, 13'd8191,
                                                 13'd640, 13'd3, 13'd4095, 13'd1024};

    initial begin
        logic [DIM_W-1:0] wv;
        logic [DIM_W-1:0] hv;
        board = new();
        width_reg = 13'd1;
        height_reg = 13'd1;
        sender_idle = 0;
        receiver_stall = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axes, zero vector, poles, extremes, with a wide image.
        write_size(CFG_IMAGE_WIDTH, 13'd4096);
        write_size(CFG_IMAGE_HEIGHT, 13'd2048);
        send_direction('0, '0, '0);
        send_direction(24'sd1, '0, '0);
        send_direction(-24'sd1, '0, '0);
        send_direction('0, '0, 24'sd1);
        send_direction('0, '0, -24'sd1);
        send_direction('0, 24'sd5, '0);
        send_direction('0, -24'sd5, '0);
        send_direction('0, 24'sh800000, '0);
        send_direction(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_direction(24'sh800000, 24'sh800000, 24'sh800000);
        send_direction(24'sh800000, '0, 24'sh7FFFFF);
        send_direction(24'sh7FFFFF, 24'sh800000, -24'sd1);
        send_direction(-24'sd1, 24'sd1, -24'sd1);
        send_direction(24'sd1, -24'sd1, 24'sd0);
        send_direction(24'sd3, 24'sd0, -24'sd7);
        send_direction(24'sh555555, 24'shAAAAAA, 24'sh123456);
        drain();
        // Size zero and a size above the maximum.
        write_size(CFG_IMAGE_WIDTH, 13'd0);
        write_size(CFG_IMAGE_HEIGHT, 13'd8191);
        send_direction('0, -24'sd9, '0);
        send_direction(24'sd100, 24'sd3, -24'sd100);
        drain();

        // Random phases with changing sizes and idling patterns.
        for (int phase = 0; phase < 12; phase++) begin
            sender_idle = (phase < 4) ? 6 : (phase < 8) ? 80 : 0;
            receiver_stall = (phase < 4) ? 80 : (phase < 8) ? 6 : 0;
            wv = ($urandom_range(2) == 0) ? 13'($urandom) : SIZE_SET[$urandom_range(7)];
            hv = ($urandom_range(2) == 0) ? 13'($urandom) : SIZE_SET[$urandom_range(7)];
            write_size(CFG_IMAGE_WIDTH, wv);
            write_size(CFG_IMAGE_HEIGHT, hv);
            for (int n = 0; n < 90; n++) begin
                send_direction(random_component(), random_component(), random_component());
            end
            drain();
        end

        $display("Checked %0d texel results over directed axis and pole cases and",
                 board.checked);
        $display("twelve random phases of image sizes under input and output idling.");
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("** sphere_map_texel_index_unit: PASSED **");
        end else begin
            $display("** sphere_map_texel_index_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/smti_pkg.sv
hw/rtl/sphere_map_texel_index_unit.sv
tb/testbench.sv
